[rtl/wtd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package wtd_pkg;

   // waypoint table
   localparam int WAYPOINT_DEPTH = 64;
   localparam int IDX_W          = $clog2(WAYPOINT_DEPTH);
   localparam int CNT_W          = $clog2(WAYPOINT_DEPTH + 1);
   localparam int ENTRY_W        = 32;

   // field widths
   localparam int POS_W   = 16;
   localparam int DIFF_W  = 17;
   localparam int FWD_W   = 17;
   localparam int ANG_W   = 16;
   localparam int DWELL_W = 9;

   // configuration port
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 15;
   localparam int CD_W       = 10;
   localparam int HDG_W      = 15;
   localparam int WAIT_W     = 8;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_CLOSE_DISTANCE = 2'd0,
      CSR_HEADING_ENTER  = 2'd1,
      CSR_HEADING_EXIT   = 2'd2,
      CSR_WAIT_TICKS     = 2'd3
   } csr_addr_type;

   localparam logic [CD_W-1:0]   CLOSE_DISTANCE_RST = CD_W'(50);
   localparam logic [HDG_W-1:0]  HEADING_ENTER_RST  = HDG_W'(364);
   localparam logic [HDG_W-1:0]  HEADING_EXIT_RST   = HDG_W'(1092);
   localparam logic [WAIT_W-1:0] WAIT_TICKS_RST     = WAIT_W'(20);

   // iterative unit
   localparam int CORDIC_W     = 28;
   localparam int CORDIC_STEPS = 15;
   localparam int SQ_W         = 34;
   localparam int SQRT_STEPS   = 17;
   localparam int STEP_W       = $clog2(SQRT_STEPS);
   localparam int SHIFT_W      = $clog2(CORDIC_STEPS);
   localparam int BIT_SH_W     = $clog2(SQ_W);

   localparam logic [ANG_W-1:0] HALF_TURN = ANG_W'(32768);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_READ = 7'b0000010,
      ST_SQX  = 7'b0000100,
      ST_SQY  = 7'b0001000,
      ST_LIM  = 7'b0010000,
      ST_ITER = 7'b0100000,
      ST_FIN  = 7'b1000000
   } state_type;

   // arctangent of 2^-i in binary angle units
   function automatic logic [ANG_W-1:0] atan_step(input logic [SHIFT_W-1:0] i);
      logic [ANG_W-1:0] v;
      case (i)
         4'd0:    v = ANG_W'(8192);
         4'd1:    v = ANG_W'(4836);
         4'd2:    v = ANG_W'(2555);
         4'd3:    v = ANG_W'(1297);
         4'd4:    v = ANG_W'(651);
         4'd5:    v = ANG_W'(326);
         4'd6:    v = ANG_W'(163);
         4'd7:    v = ANG_W'(81);
         4'd8:    v = ANG_W'(41);
         4'd9:    v = ANG_W'(20);
         4'd10:   v = ANG_W'(10);
         4'd11:   v = ANG_W'(5);
         4'd12:   v = ANG_W'(3);
         4'd13:   v = ANG_W'(1);
         4'd14:   v = ANG_W'(1);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

[rtl/wtd_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface wtd_req_if;
   logic                                valid;
   logic                                ready;
   logic                                func;
   logic signed [wtd_pkg::POS_W-1:0]    pose_x;
   logic signed [wtd_pkg::POS_W-1:0]    pose_y;
   logic signed [wtd_pkg::ANG_W-1:0]    pose_heading;
   logic signed [wtd_pkg::POS_W-1:0]    waypoint_x;
   logic signed [wtd_pkg::POS_W-1:0]    waypoint_y;

   modport source (output valid, func, pose_x, pose_y, pose_heading, waypoint_x, waypoint_y,
                   input ready);
   modport sink   (input valid, func, pose_x, pose_y, pose_heading, waypoint_x, waypoint_y,
                   output ready);
endinterface

interface wtd_rsp_if;
   logic                                valid;
   logic                                ready;
   logic        [wtd_pkg::FWD_W-1:0]    forward_mm;
   logic signed [wtd_pkg::ANG_W-1:0]    turn_angle;
   logic                                plan_done;

   modport source (output valid, forward_mm, turn_angle, plan_done, input ready);
   modport sink   (input valid, forward_mm, turn_angle, plan_done, output ready);
endinterface

interface wtd_csr_if;
   logic                                valid;
   logic                                ready;
   logic [wtd_pkg::CSR_ADDR_W-1:0]      addr;
   logic [wtd_pkg::CSR_DATA_W-1:0]      data;

   modport source (output valid, addr, data, input ready);
   modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

[rtl/wtd_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module wtd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

[rtl/waypoint_turn_then_drive_controller.sv]
`timescale 1ns / 1ps
`default_nettype none
// Waypoint follower, turn then drive. A load item (func 0) appends a waypoint to a
// 64-entry table and is dropped when the table is full; it gives no result. A pose
// item (func 1) aims at the current waypoint and gives exactly one result: while the
// heading error is inside the hysteresis window the block drives (forward_mm is the
// floored distance), otherwise it turns (turn_angle is the wrapped heading error).
// When the plan is done a pose item gives forward 0, turn 0 and plan_done 1 straight
// from the idle state. A pose item with work to do runs one table read, three passes
// through a shared 17x17 squarer (dx, dy and the arrival radius), then 17 steps of a
// shared iteration unit that runs one CORDIC vectoring step (first 15 steps) and one
// digit of the square root per cycle, and a final state that settles dwell,
// hysteresis and outputs before its result is valid. The block takes no new item
// while a pose item is in flight or a result waits in the output register. The csr
// port is always ready; write it only while the block is idle. Entries at or beyond
// the fill count are read when the plan is done, but that read data is not used.
module waypoint_turn_then_drive_controller (
   input wire logic  clock,
   input wire logic  reset,
   wtd_req_if.sink   req_bus,
   wtd_rsp_if.source rsp_bus,
   wtd_csr_if.sink   csr_bus
);
   import wtd_pkg::*;

   // sequencer and bookkeeping
   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       cur_ff, cur_in;
   logic [DWELL_W-1:0]     dwell_ff, dwell_in;
   logic                   aligned_ff, aligned_in;
   logic [STEP_W-1:0]      step_ff, step_in;

   // configuration
   logic [CD_W-1:0]        close_distance_ff;
   logic [HDG_W-1:0]       heading_enter_ff;
   logic [HDG_W-1:0]       heading_exit_ff;
   logic [WAIT_W-1:0]      wait_ticks_ff;

   // per item datapath
   logic signed [POS_W-1:0]    pose_x_ff, pose_x_in;
   logic signed [POS_W-1:0]    pose_y_ff, pose_y_in;
   logic        [ANG_W-1:0]    heading_ff, heading_in;
   logic signed [DIFF_W-1:0]   dx_ff, dx_in;
   logic signed [DIFF_W-1:0]   dy_ff, dy_in;
   logic        [SQ_W-1:0]     d2_ff, d2_in;
   logic                       close_ff, close_in;
   logic                       zero_ff, zero_in;
   logic signed [CORDIC_W-1:0] cx_ff, cx_in;
   logic signed [CORDIC_W-1:0] cy_ff, cy_in;
   logic        [ANG_W-1:0]    cz_ff, cz_in;
   logic        [SQ_W-1:0]     rem_ff, rem_in;
   logic        [SQ_W-1:0]     root_ff, root_in;

   // result register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic        [FWD_W-1:0]    fwd_ff, fwd_in;
   logic signed [ANG_W-1:0]    turn_ff, turn_in;
   logic                       done_ff, done_in;

   // table memory
   logic                       ram_wr_en;
   logic                       ram_rd_en;
   logic [ENTRY_W-1:0]         ram_rd_data;

   // combinational helpers
   logic                       req_fire;
   logic signed [DIFF_W-1:0]   mul_a;
   logic signed [SQ_W-1:0]     mul_p;
   logic signed [CORDIC_W-1:0] x0, y0;
   logic signed [CORDIC_W-1:0] xs, ys;
   logic [SHIFT_W-1:0]         sh;
   logic [BIT_SH_W-1:0]        bit_sh;
   logic [SQ_W-1:0]            sq_bit, sq_sum;
   logic [ANG_W-1:0]           ang, err;
   logic [ANG_W:0]             mag;
   logic [HDG_W-1:0]           thr;
   logic [DWELL_W-1:0]         dwell_inc;
   logic                       advance;
   logic [CNT_W-1:0]           cur_next;
   logic signed [POS_W-1:0]    aim_x, aim_y;

   assign req_fire      = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign csr_bus.ready = 1'b1;

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.forward_mm = fwd_ff;
   assign rsp_bus.turn_angle = turn_ff;
   assign rsp_bus.plan_done  = done_ff;

   // table write on load items with room left, read of the current aim on pose items
   assign ram_wr_en = req_fire && !req_bus.func && (count_ff < CNT_W'(WAYPOINT_DEPTH));
   assign ram_rd_en = req_fire && req_bus.func;

   wtd_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(WAYPOINT_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data ({req_bus.waypoint_x, req_bus.waypoint_y}),
      .rd_en   (ram_rd_en),
      .rd_addr (cur_ff[IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   assign aim_x = ram_rd_data[ENTRY_W-1:POS_W];
   assign aim_y = ram_rd_data[POS_W-1:0];

   // shared squarer: dx, then dy, then the arrival radius
   always_comb begin
      case (state_ff)
         ST_SQX:  mul_a = dx_ff;
         ST_SQY:  mul_a = dy_ff;
         default: mul_a = $signed({{(DIFF_W-CD_W){1'b0}}, close_distance_ff});
      endcase
   end
   assign mul_p = mul_a * mul_a;

   // cordic start vector: dx*256, dy*256, folded into the right half plane
   assign x0 = CORDIC_W'(dx_ff) <<< 8;
   assign y0 = CORDIC_W'(dy_ff) <<< 8;

   // one square root digit per step, and one cordic rotation in each of the first 15 steps
   assign sh     = step_ff[SHIFT_W-1:0];
   assign xs     = cx_ff >>> sh;
   assign ys     = cy_ff >>> sh;
   assign bit_sh = BIT_SH_W'(2 * (SQRT_STEPS - 1)) - BIT_SH_W'({step_ff, 1'b0});
   assign sq_bit = SQ_W'(1) << bit_sh;
   assign sq_sum = root_ff + sq_bit;

   // heading error and hysteresis threshold
   assign ang = zero_ff ? '0 : cz_ff;
   assign err = ang - heading_ff;
   assign mag = err[ANG_W-1] ? ((ANG_W+1)'(0) - {err[ANG_W-1], err}) : {1'b0, err};
   assign thr = aligned_ff ? heading_exit_ff : heading_enter_ff;

   // dwell counter and waypoint advance
   assign dwell_inc = dwell_ff + DWELL_W'(1);
   assign advance   = close_ff && (dwell_inc > {1'b0, wait_ticks_ff});
   assign cur_next  = advance ? cur_ff + CNT_W'(1) : cur_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      cur_in       = cur_ff;
      dwell_in     = dwell_ff;
      aligned_in   = aligned_ff;
      step_in      = step_ff;
      pose_x_in    = pose_x_ff;
      pose_y_in    = pose_y_ff;
      heading_in   = heading_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      d2_in        = d2_ff;
      close_in     = close_ff;
      zero_in      = zero_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      fwd_in       = fwd_ff;
      turn_in      = turn_ff;
      done_in      = done_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (!req_bus.func) begin
                  if (ram_wr_en) begin
                     count_in = count_ff + CNT_W'(1);
                  end
               end else if (cur_ff >= count_ff) begin
                  // plan done: answer at once, no state change
                  rsp_valid_in = 1'b1;
                  fwd_in       = '0;
                  turn_in      = '0;
                  done_in      = 1'b1;
               end else begin
                  pose_x_in  = req_bus.pose_x;
                  pose_y_in  = req_bus.pose_y;
                  heading_in = req_bus.pose_heading;
                  state_in   = ST_READ;
               end
            end
         end
         ST_READ: begin
            dx_in    = DIFF_W'(aim_x) - DIFF_W'(pose_x_ff);
            dy_in    = DIFF_W'(aim_y) - DIFF_W'(pose_y_ff);
            state_in = ST_SQX;
         end
         ST_SQX: begin
            d2_in    = $unsigned(mul_p);
            zero_in  = (dx_ff == '0) && (dy_ff == '0);
            state_in = ST_SQY;
         end
         ST_SQY: begin
            d2_in    = d2_ff + $unsigned(mul_p);
            state_in = ST_LIM;
         end
         ST_LIM: begin
            close_in = d2_ff < $unsigned(mul_p);
            if (dx_ff[DIFF_W-1]) begin
               cx_in = -x0;
               cy_in = -y0;
               cz_in = HALF_TURN;
            end else begin
               cx_in = x0;
               cy_in = y0;
               cz_in = '0;
            end
            rem_in   = d2_ff;
            root_in  = '0;
            step_in  = '0;
            state_in = ST_ITER;
         end
         ST_ITER: begin
            if (step_ff < STEP_W'(CORDIC_STEPS)) begin
               if (!cy_ff[CORDIC_W-1]) begin
                  cx_in = cx_ff + ys;
                  cy_in = cy_ff - xs;
                  cz_in = cz_ff + atan_step(sh);
               end else begin
                  cx_in = cx_ff - ys;
                  cy_in = cy_ff + xs;
                  cz_in = cz_ff - atan_step(sh);
               end
            end
            if (rem_ff >= sq_sum) begin
               rem_in  = rem_ff - sq_sum;
               root_in = (root_ff >> 1) + sq_bit;
            end else begin
               root_in = root_ff >> 1;
            end
            if (step_ff == STEP_W'(SQRT_STEPS - 1)) begin
               state_in = ST_FIN;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_FIN: begin
            if (!close_ff || advance) begin
               dwell_in = '0;
            end else begin
               dwell_in = dwell_inc;
            end
            cur_in = cur_next;
            if (mag < (ANG_W+1)'(thr)) begin
               aligned_in = 1'b1;
               fwd_in     = root_ff[FWD_W-1:0];
               turn_in    = '0;
            end else begin
               aligned_in = 1'b0;
               fwd_in     = '0;
               turn_in    = err;
            end
            done_in      = (cur_next == count_ff);
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cur_ff       <= '0;
         dwell_ff     <= '0;
         aligned_ff   <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cur_ff       <= cur_in;
         dwell_ff     <= dwell_in;
         aligned_ff   <= aligned_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // configuration registers, unknown indexes fall through
   always_ff @(posedge clock) begin
      if (reset) begin
         close_distance_ff <= CLOSE_DISTANCE_RST;
         heading_enter_ff  <= HEADING_ENTER_RST;
         heading_exit_ff   <= HEADING_EXIT_RST;
         wait_ticks_ff     <= WAIT_TICKS_RST;
      end else if (csr_bus.valid && csr_bus.ready) begin
         case (csr_addr_type'(csr_bus.addr))
            CSR_CLOSE_DISTANCE: close_distance_ff <= csr_bus.data[CD_W-1:0];
            CSR_HEADING_ENTER:  heading_enter_ff  <= csr_bus.data[HDG_W-1:0];
            CSR_HEADING_EXIT:   heading_exit_ff   <= csr_bus.data[HDG_W-1:0];
            CSR_WAIT_TICKS:     wait_ticks_ff     <= csr_bus.data[WAIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pose_x_ff  <= pose_x_in;
      pose_y_ff  <= pose_y_in;
      heading_ff <= heading_in;
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      d2_ff      <= d2_in;
      close_ff   <= close_in;
      zero_ff    <= zero_in;
      cx_ff      <= cx_in;
      cy_ff      <= cy_in;
      cz_ff      <= cz_in;
      rem_ff     <= rem_in;
      root_ff    <= root_in;
      fwd_ff     <= fwd_in;
      turn_ff    <= turn_in;
      done_ff    <= done_in;
   end

`ifndef SYNTH
   // the aim index never runs past the fill count
   a_cur_in_range: assert property (@(posedge clock) disable iff (reset)
      cur_ff <= count_ff)
      else $error("current index beyond waypoint count");

   // a result either drives or turns, never both
   a_drive_or_turn: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (fwd_ff == '0 || turn_ff == '0))
      else $error("result both drives and turns");

   // a result appears only from the final step or the plan-done shortcut
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN || state_ff == ST_IDLE))
      else $error("result raised from an unexpected state");

   // the iteration counter stays inside the square root length
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ITER |-> step_ff < STEP_W'(SQRT_STEPS))
      else $error("iteration step out of range");
`endif

endmodule
`default_nettype wire
